// ===== src/generational_handle_slot_pool_unit_macros.svh =====
// Assertion macros for the generational handle slot pool.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef GENERATIONAL_HANDLE_SLOT_POOL_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_SLOT_POOL_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define GHSP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define GHSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ghsp_pkg.sv =====
// Shared types and constants for the generational handle slot pool.
// No dependencies.
package ghsp_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int GEN_BITS   = 16;
    localparam int REF_BITS   = 16;
    localparam int TAG_BITS   = 32;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam logic [2:0] OP_ALLOC       = 3'd0;
    localparam logic [2:0] OP_ADD_REF     = 3'd1;
    localparam logic [2:0] OP_RELEASE     = 3'd2;
    localparam logic [2:0] OP_DESTROY     = 3'd3;
    localparam logic [2:0] OP_DESTROY_TAG = 3'd4;
    localparam logic [2:0] OP_LOOKUP      = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]          opcode;
        logic                handle_present;
        logic [IDX_W-1:0]    slot_index;
        logic [GEN_BITS-1:0] handle_generation;
        logic [TAG_BITS-1:0] resource_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_W-1:0]    out_slot;
        logic [GEN_BITS-1:0] out_generation;
        logic [TAG_BITS-1:0] out_tag;
        logic                must_release;
        logic                handle_valid;
    } t_out_item;

    typedef struct packed {
        logic                active;
        logic [TAG_BITS-1:0] tag;
        logic [GEN_BITS-1:0] gen;
        logic [REF_BITS-1:0] refs;
    } t_slot;

endpackage

// ===== src/ghsp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ghsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/generational_handle_slot_pool_unit.sv =====
// Handle operations pass from accept through S_HEX to S_DONE, allocation from the free stack
// through S_AGEN and S_AWR; allocation from the high-water mark and rejected items go straight
// to S_DONE; destroy by tag scans one slot a cycle through the slot RAM read port in S_SCMP.
// One item at a time; a new item is taken while the previous result waits at the output.
// Synchronous active-low reset empties the pool at once: slots past the high-water count are
// never read, so the slot RAM needs no clearing pass.
// Depends on ghsp_pkg, ghsp_ram and the assertion macro header.
`include "generational_handle_slot_pool_unit_macros.svh"

module generational_handle_slot_pool_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ghsp_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ghsp_pkg::t_out_item o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AGEN = 3'd1;
    localparam logic [2:0] S_AWR  = 3'd2;
    localparam logic [2:0] S_HEX  = 3'd3;
    localparam logic [2:0] S_SCMP = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam int IW = ghsp_pkg::IDX_W;
    localparam int CW = ghsp_pkg::CNT_W;
    localparam int RW = ghsp_pkg::REF_BITS;
    localparam logic [CW-1:0] FULL_CNT = CW'(ghsp_pkg::SLOT_COUNT);

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_fdepth, n_fdepth;
    logic [CW-1:0]       r_used, n_used;
    logic                r_out_valid, n_out_valid;
    logic [IW-1:0]       r_idx, n_idx;
    ghsp_pkg::t_in_item  r_in;
    ghsp_pkg::t_out_item r_pend, n_pend;
    ghsp_pkg::t_out_item r_out;

    logic                slot_we;
    logic [IW-1:0]       slot_waddr, slot_raddr;
    ghsp_pkg::t_slot     slot_wdata, slot_rdata;
    logic                stk_we;
    logic [IW-1:0]       stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic                in_acc;
    logic                out_load;

    ghsp_ram #(
        .WIDTH ($bits(ghsp_pkg::t_slot)),
        .DEPTH (ghsp_pkg::SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    ghsp_ram #(
        .WIDTH (IW),
        .DEPTH (ghsp_pkg::SLOT_COUNT)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    function automatic ghsp_pkg::t_slot f_freed(ghsp_pkg::t_slot s);
        ghsp_pkg::t_slot f;
        f     = '0;
        f.gen = s.gen + 1'b1;
        return f;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state    = r_state;
        n_fdepth   = r_fdepth;
        n_used     = r_used;
        n_idx      = r_idx;
        n_pend     = r_pend;
        slot_we    = 1'b0;
        slot_waddr = r_idx;
        slot_wdata = slot_rdata;
        slot_raddr = r_idx;
        stk_we     = 1'b0;
        stk_waddr  = r_fdepth[IW-1:0];
        stk_wdata  = r_idx;
        // top of the free stack is always being read while idle
        stk_raddr  = IW'(r_fdepth - 1'b1);

        unique case (r_state)
            S_IDLE: begin
                slot_raddr = (i_in.opcode == ghsp_pkg::OP_DESTROY_TAG) ? '0 : i_in.slot_index;
                if (i_in_valid) begin
                    n_idx         = i_in.slot_index;
                    n_pend        = '0;
                    n_pend.status = ghsp_pkg::ST_INVALID;
                    n_state       = S_DONE;
                    unique case (i_in.opcode)
                        ghsp_pkg::OP_ALLOC: begin
                            if (r_fdepth != '0) begin
                                n_fdepth = r_fdepth - 1'b1;
                                n_state  = S_AGEN;
                            end else if (r_used < FULL_CNT) begin
                                // fresh slot above the high-water mark: generation zero
                                slot_we           = 1'b1;
                                slot_waddr        = r_used[IW-1:0];
                                slot_wdata.active = 1'b1;
                                slot_wdata.tag    = i_in.resource_tag;
                                slot_wdata.gen    = '0;
                                slot_wdata.refs   = RW'(1);
                                n_used            = r_used + 1'b1;
                                n_pend.status     = ghsp_pkg::ST_OK;
                                n_pend.out_slot   = r_used[IW-1:0];
                            end else begin
                                n_pend.status = ghsp_pkg::ST_FULL;
                            end
                        end
                        ghsp_pkg::OP_ADD_REF, ghsp_pkg::OP_RELEASE,
                        ghsp_pkg::OP_DESTROY, ghsp_pkg::OP_LOOKUP: begin
                            if (!i_in.handle_present) begin
                                n_pend.status = ghsp_pkg::ST_INVALID;
                            end else if (CW'(i_in.slot_index) >= r_used) begin
                                n_pend.status = ghsp_pkg::ST_FAIL;
                            end else begin
                                n_state = S_HEX;
                            end
                        end
                        ghsp_pkg::OP_DESTROY_TAG: begin
                            if (i_in.resource_tag == '0) begin
                                n_pend.status = ghsp_pkg::ST_INVALID;
                            end else if (r_used == '0) begin
                                n_pend.status       = ghsp_pkg::ST_OK;
                                n_pend.out_tag      = i_in.resource_tag;
                                n_pend.must_release = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCMP;
                            end
                        end
                        default: begin
                            n_pend.status = ghsp_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            S_AGEN: begin
                // popped index arrives; fetch its generation
                n_idx      = stk_rdata;
                slot_raddr = stk_rdata;
                n_state    = S_AWR;
            end

            S_AWR: begin
                slot_we                = 1'b1;
                slot_wdata.active      = 1'b1;
                slot_wdata.tag         = r_in.resource_tag;
                slot_wdata.gen         = slot_rdata.gen;
                slot_wdata.refs        = RW'(1);
                n_pend                 = '0;
                n_pend.status          = ghsp_pkg::ST_OK;
                n_pend.out_slot        = r_idx;
                n_pend.out_generation  = slot_rdata.gen;
                n_state                = S_DONE;
            end

            S_HEX: begin
                n_pend  = '0;
                n_state = S_DONE;
                if (slot_rdata.gen != r_in.handle_generation) begin
                    n_pend.status = ghsp_pkg::ST_FAIL;
                end else begin
                    n_pend.out_slot = r_idx;
                    unique case (r_in.opcode)
                        ghsp_pkg::OP_ADD_REF: begin
                            n_pend.status = ghsp_pkg::ST_OK;
                            slot_we       = 1'b1;
                            if (slot_rdata.refs != '1) begin
                                slot_wdata.refs = slot_rdata.refs + 1'b1;
                            end
                        end
                        ghsp_pkg::OP_RELEASE: begin
                            n_pend.status = ghsp_pkg::ST_OK;
                            slot_we       = 1'b1;
                            if (slot_rdata.refs <= RW'(1)) begin
                                slot_wdata.refs = '0;
                                if (slot_rdata.active) begin
                                    slot_wdata = f_freed(slot_rdata);
                                    if (r_fdepth < FULL_CNT) begin
                                        stk_we   = 1'b1;
                                        n_fdepth = r_fdepth + 1'b1;
                                    end
                                    if (slot_rdata.tag != '0) begin
                                        n_pend.out_tag      = slot_rdata.tag;
                                        n_pend.must_release = 1'b1;
                                    end
                                end
                            end else begin
                                slot_wdata.refs = slot_rdata.refs - 1'b1;
                            end
                        end
                        ghsp_pkg::OP_DESTROY: begin
                            n_pend.status = ghsp_pkg::ST_FAIL;
                            if (slot_rdata.active) begin
                                slot_we    = 1'b1;
                                slot_wdata = f_freed(slot_rdata);
                                if (r_fdepth < FULL_CNT) begin
                                    stk_we   = 1'b1;
                                    n_fdepth = r_fdepth + 1'b1;
                                end
                                if (slot_rdata.tag != '0) begin
                                    n_pend.status       = ghsp_pkg::ST_OK;
                                    n_pend.out_tag      = slot_rdata.tag;
                                    n_pend.must_release = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // lookup
                            n_pend.status         = ghsp_pkg::ST_OK;
                            n_pend.out_generation = slot_rdata.gen;
                            n_pend.out_tag        = slot_rdata.tag;
                            n_pend.handle_valid   = (slot_rdata.tag != '0);
                        end
                    endcase
                end
            end

            S_SCMP: begin
                // compare slot r_idx while the next slot is being read
                slot_raddr          = r_idx + 1'b1;
                n_pend              = '0;
                n_pend.status       = ghsp_pkg::ST_OK;
                n_pend.out_tag      = r_in.resource_tag;
                n_pend.must_release = 1'b1;
                if (slot_rdata.active && (slot_rdata.tag == r_in.resource_tag)) begin
                    slot_we         = 1'b1;
                    slot_wdata      = f_freed(slot_rdata);
                    n_pend.out_slot = r_idx;
                    if (r_fdepth < FULL_CNT) begin
                        stk_we   = 1'b1;
                        n_fdepth = r_fdepth + 1'b1;
                    end
                    n_state = S_DONE;
                end else if ((CW'(r_idx) + 1'b1) < r_used) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fdepth    <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fdepth    <= n_fdepth;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pend <= n_pend;
        if (in_acc) begin
            r_in <= i_in;
        end
        if (out_load) begin
            r_out <= r_pend;
        end
    end

    `GHSP_ASSERT_ALWAYS(a_free_within_used, r_fdepth <= r_used, "free stack too deep")
    `GHSP_ASSERT_ALWAYS(a_used_in_range, r_used <= FULL_CNT, "high-water count past slot count")
    `GHSP_ASSERT_NEXT(a_busy_after_accept, in_acc, r_state != S_IDLE, "idle after accepted beat")
    `GHSP_ASSERT_NEXT(a_result_loaded, out_load, o_out_valid && (r_state == S_IDLE), "result lost")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for generational_handle_slot_pool_unit.
// Drives handle operations, predicts each result from its own copy of the slot table.
// Depends on ghsp_pkg and the RTL of the pool.
module testbench;
    import ghsp_pkg::*;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam int LIMIT_TIME       = 16_000_000;
    localparam int TAIL_CYCLES      = 80;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int RANDOM_ITEMS     = 720;
    localparam int REF_STEPS        = 16;
    localparam int GEN_STEPS        = 8;
    localparam int MAX_PRINTED      = 50;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_beat;

    // Predicted slot table
    logic [TAG_BITS-1:0] pool_tag    [SLOT_COUNT];
    logic [GEN_BITS-1:0] pool_gen    [SLOT_COUNT];
    logic [REF_BITS-1:0] pool_refs   [SLOT_COUNT];
    logic                pool_active [SLOT_COUNT];
    logic [IDX_W-1:0]    pool_free   [SLOT_COUNT];
    int                  pool_free_depth;
    int                  pool_used;

    t_out_item pool_results_due[$];
    int        mismatch_count = 0;
    bit        gaps_on = 1'b1;
    bit        stalls_on = 1'b1;
    int        hold_requests = 0;
    int        holds_served = 0;

    generational_handle_slot_pool_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void pool_reset();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            pool_tag[i]    = '0;
            pool_gen[i]    = '0;
            pool_refs[i]   = '0;
            pool_active[i] = 1'b0;
            pool_free[i]   = '0;
        end
        pool_free_depth = 0;
        pool_used       = 0;
    endfunction

    function automatic logic [1:0] handle_status(input t_in_item it);
        if (!it.handle_present) return ST_INVALID;
        if (int'(it.slot_index) >= pool_used) return ST_FAIL;
        if (pool_gen[it.slot_index] != it.handle_generation) return ST_FAIL;
        return ST_OK;
    endfunction

    // Free an active slot: clear it, bump its generation, push it on the free stack.
    function automatic bit retire_slot(input int s, output logic [TAG_BITS-1:0] old_tag);
        old_tag = '0;
        if (s >= pool_used || !pool_active[s]) return 1'b0;
        old_tag        = pool_tag[s];
        pool_tag[s]    = '0;
        pool_refs[s]   = '0;
        pool_active[s] = 1'b0;
        pool_gen[s]    = pool_gen[s] + 1'b1;
        if (pool_free_depth < SLOT_COUNT) begin
            pool_free[pool_free_depth] = IDX_W'(s);
            pool_free_depth++;
        end
        return 1'b1;
    endfunction

    function automatic t_out_item predict_pool_result(input t_in_item it);
        t_out_item           res;
        int                  s;
        bit                  freed;
        bit                  hit;
        logic [TAG_BITS-1:0] old_tag;
        res        = '0;
        res.status = ST_INVALID;
        s          = int'(it.slot_index);
        case (it.opcode)
            OP_ALLOC: begin
                res.status = ST_FULL;
                if (pool_free_depth > 0) begin
                    pool_free_depth--;
                    s          = int'(pool_free[pool_free_depth]);
                    res.status = ST_OK;
                end else if (pool_used < SLOT_COUNT) begin
                    s = pool_used;
                    pool_used++;
                    res.status = ST_OK;
                end
                if (res.status == ST_OK) begin
                    pool_tag[s]        = it.resource_tag;
                    pool_refs[s]       = REF_BITS'(1);
                    pool_active[s]     = 1'b1;
                    res.out_slot       = IDX_W'(s);
                    res.out_generation = pool_gen[s];
                end
            end
            OP_ADD_REF: begin
                res.status = handle_status(it);
                if (res.status == ST_OK) begin
                    if (pool_refs[s] != '1) pool_refs[s]++;
                    res.out_slot = it.slot_index;
                end
            end
            OP_RELEASE: begin
                res.status = handle_status(it);
                if (res.status == ST_OK) begin
                    res.out_slot = it.slot_index;
                    if (pool_refs[s] <= 1) begin
                        pool_refs[s] = '0;
                        freed = retire_slot(s, old_tag);
                        if (freed && old_tag != '0) begin
                            res.out_tag      = old_tag;
                            res.must_release = 1'b1;
                        end
                    end else begin
                        pool_refs[s]--;
                    end
                end
            end
            OP_DESTROY: begin
                res.status = handle_status(it);
                if (res.status == ST_OK) begin
                    res.out_slot = it.slot_index;
                    freed = retire_slot(s, old_tag);
                    if (freed && old_tag != '0) begin
                        res.out_tag      = old_tag;
                        res.must_release = 1'b1;
                    end else begin
                        res.status = ST_FAIL;
                    end
                end
            end
            OP_DESTROY_TAG: begin
                if (it.resource_tag != '0) begin
                    // A miss still tells the caller to free the resource.
                    res.status       = ST_OK;
                    res.out_tag      = it.resource_tag;
                    res.must_release = 1'b1;
                    hit              = 1'b0;
                    for (int i = 0; i < pool_used && !hit; i++) begin
                        if (pool_active[i] && pool_tag[i] == it.resource_tag) begin
                            hit          = 1'b1;
                            freed        = retire_slot(i, old_tag);
                            res.out_slot = IDX_W'(i);
                        end
                    end
                end
            end
            OP_LOOKUP: begin
                res.status = handle_status(it);
                if (res.status == ST_OK) begin
                    res.out_slot       = it.slot_index;
                    res.out_generation = pool_gen[s];
                    res.out_tag        = pool_tag[s];
                    res.handle_valid   = (pool_tag[s] != '0);
                end
            end
            default: res.status = ST_INVALID;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [TAG_BITS-1:0] got,
                                   input logic [TAG_BITS-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // Predict on each accepted input beat, check each accepted output beat.
    always @(posedge clk) begin : result_monitor
        t_out_item due;
        if (rst_n) begin
            if (in_valid && in_ready)
                pool_results_due = {pool_results_due, predict_pool_result(in_beat)};
            if (out_valid && out_ready) begin
                if (pool_results_due.size() == 0) begin
                    report_mismatch("result with nothing due, tag", out_beat.out_tag, '0);
                end else begin
                    due = pool_results_due.pop_front();
                    if (out_beat.status !== due.status)
                        report_mismatch("status", out_beat.status, due.status);
                    if (out_beat.out_slot !== due.out_slot)
                        report_mismatch("out_slot", out_beat.out_slot, due.out_slot);
                    if (out_beat.out_generation !== due.out_generation)
                        report_mismatch("out_generation", out_beat.out_generation,
                                        due.out_generation);
                    if (out_beat.out_tag !== due.out_tag)
                        report_mismatch("out_tag", out_beat.out_tag, due.out_tag);
                    if (out_beat.must_release !== due.must_release)
                        report_mismatch("must_release", out_beat.must_release,
                                        due.must_release);
                    if (out_beat.handle_valid !== due.handle_valid)
                        report_mismatch("handle_valid", out_beat.handle_valid,
                                        due.handle_valid);
                end
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin : result_sink
        forever begin
            if (holds_served != hold_requests) begin
                // Hold off long enough for the block to back up into its input.
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else if (stalls_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one beat and return at the edge that accepts it; valid stays up for a
    // back-to-back beat.
    task automatic send_op(input logic [2:0] op, input logic present,
                           input logic [IDX_W-1:0] slot, input logic [GEN_BITS-1:0] gen,
                           input logic [TAG_BITS-1:0] tag);
        t_in_item beat;
        int       gap;
        beat.opcode            = op;
        beat.handle_present    = present;
        beat.slot_index        = slot;
        beat.handle_generation = gen;
        beat.resource_tag      = tag;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic settle_pool();
        in_valid <= 1'b0;
        do @(posedge clk); while (pool_results_due.size() != 0);
    endtask

    function automatic int next_alloc_slot();
        if (pool_free_depth > 0) return int'(pool_free[pool_free_depth - 1]);
        return pool_used;
    endfunction

    task automatic test_empty_pool();
        send_op(OP_LOOKUP, 1'b0, '0, '0, '0);
        send_op(OP_LOOKUP, 1'b1, '0, '0, '0);
        send_op(OP_RELEASE, 1'b1, '1, '1, '1);
        send_op(OP_DESTROY_TAG, 1'b1, '0, '0, '0);
        send_op(OP_DESTROY_TAG, 1'b0, '1, '1, '1);
        send_op(OP_UNUSED_6, 1'b1, '1, '1, '1);
        send_op(OP_UNUSED_7, 1'b0, '0, '0, 32'h1);
    endtask

    task automatic test_handle_lifecycle();
        send_op(OP_ALLOC, 1'b0, '1, '1, '1);
        send_op(OP_ALLOC, 1'b1, '0, '0, '0);              // zero tag is stored
        send_op(OP_ALLOC, 1'b0, '0, '0, 32'd1);
        send_op(OP_ADD_REF, 1'b1, 6'd0, 16'd0, '0);
        send_op(OP_LOOKUP, 1'b1, 6'd0, 16'd0, '0);
        send_op(OP_LOOKUP, 1'b1, 6'd1, 16'd0, '0);
        send_op(OP_LOOKUP, 1'b1, 6'd0, 16'd1, '0);         // wrong generation
        send_op(OP_RELEASE, 1'b1, 6'd0, 16'd0, '0);
        send_op(OP_RELEASE, 1'b1, 6'd0, 16'd0, '0);        // count hits zero, slot freed
        send_op(OP_LOOKUP, 1'b1, 6'd0, 16'd0, '0);         // stale handle
        send_op(OP_ADD_REF, 1'b1, 6'd0, 16'd1, '0);        // inactive slot still counts
        send_op(OP_RELEASE, 1'b1, 6'd0, 16'd1, '0);
        send_op(OP_DESTROY, 1'b1, 6'd0, 16'd1, '0);        // inactive: fails
        send_op(OP_DESTROY, 1'b1, 6'd1, 16'd0, '0);        // active with zero tag
        send_op(OP_ALLOC, 1'b0, '0, '0, 32'd7);            // reuse from free stack
        send_op(OP_DESTROY_TAG, 1'b1, '0, '0, 32'd1);
        send_op(OP_DESTROY_TAG, 1'b1, '0, '0, 32'd7);
        send_op(OP_ADD_REF, 1'b0, 6'd2, 16'd0, '0);
    endtask

    // Stack up references on one slot back to back, release one, then look it up and destroy it.
    task automatic test_ref_counting();
        int                  s;
        logic [GEN_BITS-1:0] g;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        settle_pool();
        s = next_alloc_slot();
        g = pool_gen[s];
        send_op(OP_ALLOC, 1'b0, '0, '0, 32'h5A5A_0001);
        for (int i = 0; i < REF_STEPS; i++)
            send_op(OP_ADD_REF, 1'b1, IDX_W'(s), g, '0);
        send_op(OP_RELEASE, 1'b1, IDX_W'(s), g, '0);
        send_op(OP_LOOKUP, 1'b1, IDX_W'(s), g, '0);
        send_op(OP_DESTROY, 1'b1, IDX_W'(s), g, '0);
    endtask

    // Cycle one slot through allocate and destroy, stepping its generation each time.
    task automatic test_generation_reuse();
        int                  s;
        logic [GEN_BITS-1:0] g;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        settle_pool();
        s = next_alloc_slot();
        g = pool_gen[s];
        for (int i = 0; i < GEN_STEPS; i++) begin
            send_op(OP_ALLOC, 1'b0, '0, '0, TAG_BITS'(i + 1));
            send_op(OP_DESTROY, 1'b1, IDX_W'(s), g, '0);
            g = g + 1'b1;
        end
        send_op(OP_ALLOC, 1'b0, '0, '0, 32'hFFFF_0000);
        send_op(OP_LOOKUP, 1'b1, IDX_W'(s), g, '0);
    endtask

    function automatic logic [TAG_BITS-1:0] pick_tag(input logic [2:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == OP_DESTROY_TAG && r < 60 && pool_used > 0)
            return pool_tag[$urandom_range(0, pool_used - 1)];
        if (r < 75) return $urandom_range(1, 6);
        if (r < 82) return '0;
        if (r < 86) return '1;
        return $urandom;
    endfunction

    task automatic send_random_op(input int alloc_pct);
        logic [2:0]          op;
        logic                present;
        logic [IDX_W-1:0]    slot;
        logic [GEN_BITS-1:0] gen;
        int                  r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            op = OP_ALLOC;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 20)      op = OP_ADD_REF;
            else if (r < 45) op = OP_RELEASE;
            else if (r < 65) op = OP_DESTROY;
            else if (r < 78) op = OP_DESTROY_TAG;
            else if (r < 95) op = OP_LOOKUP;
            else             op = r[0] ? OP_UNUSED_6 : OP_UNUSED_7;
        end
        r = $urandom_range(0, 99);
        if (r < 85 && pool_used > 0) begin
            present = 1'b1;
            slot    = IDX_W'($urandom_range(0, pool_used - 1));
            gen     = pool_gen[slot];
        end else if (r < 92 && pool_used > 0) begin
            // stale, current or next generation on a used slot
            present = 1'b1;
            slot    = IDX_W'($urandom_range(0, pool_used - 1));
            gen     = pool_gen[slot] + GEN_BITS'($urandom_range(1, 3)) - 16'd2;
        end else begin
            present = 1'($urandom_range(0, 1));
            slot    = IDX_W'($urandom);
            gen     = GEN_BITS'($urandom);
        end
        send_op(op, present, slot, gen, pick_tag(op));
    endtask

    task automatic test_pool_exhaustion();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        for (int i = 0; i < SLOT_COUNT + 6; i++)
            send_op(OP_ALLOC, 1'($urandom_range(0, 1)), IDX_W'($urandom),
                    GEN_BITS'($urandom), pick_tag(OP_ALLOC));
        send_op(OP_DESTROY_TAG, 1'b1, '0, '0, 32'hABCD_1234);   // full scan, miss
        for (int i = 0; i < 4; i++)
            send_op(OP_DESTROY_TAG, 1'b1, '0, '0, pick_tag(OP_DESTROY_TAG));
    endtask

    task automatic test_random_traffic();
        int alloc_pct;
        int r;
        alloc_pct = 30;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                gaps_on   = $urandom_range(0, 3) != 0;
                stalls_on = $urandom_range(0, 3) != 0;
                r = $urandom_range(0, 2);
                alloc_pct = (r == 0) ? 60 : (r == 1) ? 30 : 8;
            end
            if (n == RANDOM_ITEMS / 2) hold_requests++;
            send_random_op(alloc_pct);
        end
    endtask

    initial begin
        pool_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pool();
        test_handle_lifecycle();
        test_ref_counting();
        test_generation_reuse();
        test_pool_exhaustion();
        test_random_traffic();
        settle_pool();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/ghsp_pkg.sv
src/ghsp_ram.sv
src/generational_handle_slot_pool_unit.sv
dv/testbench.sv
